### hdl/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Holds if antecedent implies consequent at the same edge.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Holds if antecedent implies consequent in the following cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/m4pt_pkg.sv
`timescale 1ns / 1ps
package m4pt_pkg;
    localparam int FRAC_BITS = 16;
    localparam int NUM_REGS = 8;
    localparam int IDX_W = 3;
    localparam int SUM_W = 68;
    localparam int NUM_W = SUM_W + FRAC_BITS + 2;
    localparam int DIV_STEPS = 34;

    localparam logic CMD_POINT = 1'b0;
    localparam logic CMD_VECTOR = 1'b1;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_WZERO = 2'd1;
    localparam logic [1:0] ST_SAT = 2'd2;

    localparam logic [63:0] ONE64 = 64'(1) << FRAC_BITS;
    localparam logic [63:0] CFG_RESET [NUM_REGS] = '{
        ONE64, 64'd0, ONE64 << 32, 64'd0, 64'd0, ONE64, 64'd0, ONE64 << 32
    };

    typedef struct packed {
        logic                command;
        logic signed [31:0]  in_x;
        logic signed [31:0]  in_y;
        logic signed [31:0]  in_z;
    } item_in_t;

    typedef struct packed {
        logic signed [31:0]  out_x;
        logic signed [31:0]  out_y;
        logic signed [31:0]  out_z;
        logic [1:0]          status;
    } item_out_t;
endpackage

### hdl/m4pt_if.sv
`timescale 1ns / 1ps
interface m4pt_in_if import m4pt_pkg::*; ();
    logic     valid;
    logic     ready;
    item_in_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface m4pt_out_if import m4pt_pkg::*; ();
    logic      valid;
    logic      ready;
    item_out_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface m4pt_cfg_if import m4pt_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] index;
    logic [63:0]      wdata;
    modport source (output valid, output index, output wdata, input ready);
    modport sink (input valid, input index, input wdata, output ready);
endinterface

### hdl/m4pt_divpipe.sv
`timescale 1ns / 1ps
// Pipelined restoring divider: one quotient bit per stage, three lanes.
// Quotient is bounded to DIV_STEPS bits; anything bigger saturates anyway.
module m4pt_divpipe import m4pt_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 vld,
    input  logic [2:0][NUM_W-1:0] num,
    input  logic [NUM_W-1:0]     den,
    input  logic [2:0]           neg,
    input  logic                 wzero,
    output logic                 vld_o,
    output item_out_t            res
);
    localparam int S = DIV_STEPS;
    // room for the divisor shifted up by S-1 plus a borrow bit
    localparam int RW = NUM_W + S + 1;

    logic [S:0]                  v_reg;
    logic [S:0][2:0][NUM_W-1:0]  r_reg;
    logic [S:0][2:0][S-1:0]      q_reg;
    logic [S:0][NUM_W-1:0]       d_reg;
    logic [S:0][2:0]             n_reg;
    logic [S:0]                  z_reg;
    logic [S:0][2:0]             ov_reg;

    logic [S-1:0][2:0][NUM_W-1:0] r_next;
    logic [S-1:0][2:0][S-1:0]     q_next;

    always_comb
    begin
        logic [RW-1:0] t;
        logic [RW-1:0] dd;
        for (int k = 0; k < S; k++)
        begin
            for (int l = 0; l < 3; l++)
            begin
                dd = RW'(d_reg[k]) << (S - 1 - k);
                t = RW'(r_reg[k][l]) - dd;
                if (!t[RW-1])
                begin
                    r_next[k][l] = t[NUM_W-1:0];
                    q_next[k][l] = q_reg[k][l] | (S'(1) << (S - 1 - k));
                end
                else
                begin
                    r_next[k][l] = r_reg[k][l];
                    q_next[k][l] = q_reg[k][l];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[S-1:0], vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg[0] <= num;
            q_reg[0] <= '0;
            d_reg[0] <= den;
            n_reg[0] <= neg;
            z_reg[0] <= wzero;
            for (int l = 0; l < 3; l++)
            begin
                // quotient >= 2^S: compare num >= den << S
                ov_reg[0][l] <= ({{S{1'b0}}, num[l]} >= ({{S{1'b0}}, den} << S));
            end
            for (int k = 0; k < S; k++)
            begin
                r_reg[k+1] <= r_next[k];
                q_reg[k+1] <= q_next[k];
                d_reg[k+1] <= d_reg[k];
                n_reg[k+1] <= n_reg[k];
                z_reg[k+1] <= z_reg[k];
                ov_reg[k+1] <= ov_reg[k];
            end
        end
    end

    logic [2:0][31:0] comp;
    logic [2:0]       sat;

    always_comb
    begin
        logic [S-1:0] q;
        logic [S-1:0] lim;
        for (int l = 0; l < 3; l++)
        begin
            q = q_reg[S][l];
            lim = n_reg[S][l] ? S'(33'h080000000) : S'(33'h07FFFFFFF);
            if (ov_reg[S][l] || q > lim)
            begin
                sat[l] = 1'b1;
                comp[l] = n_reg[S][l] ? 32'h80000000 : 32'h7FFFFFFF;
            end
            else
            begin
                sat[l] = 1'b0;
                comp[l] = n_reg[S][l] ? 32'(-q) : q[31:0];
            end
        end
    end

    assign vld_o = v_reg[S];
    always_comb
    begin
        if (z_reg[S])
        begin
            res = '{out_x: '0, out_y: '0, out_z: '0, status: ST_WZERO};
        end
        else
        begin
            res.out_x = comp[0];
            res.out_y = comp[1];
            res.out_z = comp[2];
            res.status = (|sat) ? ST_SAT : ST_OK;
        end
    end
endmodule

### hdl/matrix4_point_transform_core.sv
`timescale 1ns / 1ps
// Channel | Dir  | Payload
// in_ch   | sink | command, in_x, in_y, in_z
// out_ch  | src  | out_x, out_y, out_z, status
// cfg_ch  | sink | index, wdata (always ready)
// One item per cycle sustained while the output is not stalled.
// Depth is set by the one-bit-per-stage divider pipeline.
// Whole pipeline advances when the output register is empty or taken.
// rst_n clears valid bits and loads the identity matrix.
module matrix4_point_transform_core import m4pt_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    m4pt_in_if.sink    in_ch,
    m4pt_out_if.source out_ch,
    m4pt_cfg_if.sink   cfg_ch
);
`include "assert_macros.svh"

    logic [63:0] cfg_reg [NUM_REGS];
    logic        en;

    assign cfg_ch.ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                cfg_reg[i] <= CFG_RESET[i];
            end
        end
        else if (cfg_ch.valid)
        begin
            cfg_reg[cfg_ch.index] <= cfg_ch.wdata;
        end
    end

    function automatic logic signed [31:0] elem(input logic [63:0] r, input logic hi);
        return hi ? r[63:32] : r[31:0];
    endfunction

    assign en = !out_ch.valid || out_ch.ready;
    assign in_ch.ready = en;

    // stage 1: capture; stage 2: products; stage 3: row sums; stage 4: prepare divide
    logic              v1_reg, v2_reg, v3_reg, v4_reg;
    item_in_t          i1_reg;
    logic              p2_reg, p3_reg, p4_reg;
    logic signed [63:0] pr_reg [4][4];
    logic signed [SUM_W-1:0] s_reg [4];
    logic              z4_reg;
    logic [2:0]        n4_reg;
    logic [SUM_W-1:0]  m4_reg [3];
    logic [SUM_W-1:0]  d4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_ch.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            i1_reg <= in_ch.data;
            p2_reg <= (i1_reg.command == CMD_POINT);
            for (int r = 0; r < 4; r++)
            begin
                pr_reg[r][0] <= elem(cfg_reg[2*r], 1'b0) * i1_reg.in_x;
                pr_reg[r][1] <= elem(cfg_reg[2*r], 1'b1) * i1_reg.in_y;
                pr_reg[r][2] <= elem(cfg_reg[2*r+1], 1'b0) * i1_reg.in_z;
                pr_reg[r][3] <= (i1_reg.command == CMD_POINT)
                    ? 64'(elem(cfg_reg[2*r+1], 1'b1)) <<< FRAC_BITS : 64'sd0;
            end
            p3_reg <= p2_reg;
            for (int r = 0; r < 4; r++)
            begin
                s_reg[r] <= SUM_W'(pr_reg[r][0]) + SUM_W'(pr_reg[r][1])
                          + SUM_W'(pr_reg[r][2]) + SUM_W'(pr_reg[r][3]);
            end
            // magnitudes and signs; in point mode a negative w flips every sign
            p4_reg <= p3_reg;
            z4_reg <= p3_reg && (s_reg[3] == '0);
            if (p3_reg)
            begin
                d4_reg <= s_reg[3][SUM_W-1] ? SUM_W'(-s_reg[3]) : SUM_W'(s_reg[3]);
            end
            else
            begin
                d4_reg <= SUM_W'(1) << FRAC_BITS;
            end
            for (int l = 0; l < 3; l++)
            begin
                n4_reg[l] <= s_reg[l][SUM_W-1] ^ (p3_reg && s_reg[3][SUM_W-1]);
                m4_reg[l] <= s_reg[l][SUM_W-1] ? SUM_W'(-s_reg[l]) : SUM_W'(s_reg[l]);
            end
        end
    end

    // numerator n = 2|num|+den, divisor 2den
    logic [2:0][NUM_W-1:0] dnum;
    logic [NUM_W-1:0]      dden;
    logic [2:0]            dneg;
    logic                  dz;

    always_comb
    begin
        logic [NUM_W-1:0] a;
        dz = z4_reg;
        dden = NUM_W'(d4_reg) << 1;
        for (int l = 0; l < 3; l++)
        begin
            a = p4_reg ? (NUM_W'(m4_reg[l]) << FRAC_BITS) : NUM_W'(m4_reg[l]);
            dneg[l] = n4_reg[l];
            dnum[l] = (a << 1) + NUM_W'(d4_reg);
        end
    end

    logic      dv;
    item_out_t dres;

    m4pt_divpipe u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .vld   (v4_reg),
        .num   (dnum),
        .den   (dz ? NUM_W'(2) : dden),
        .neg   (dneg),
        .wzero (dz),
        .vld_o (dv),
        .res   (dres)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.valid <= 1'b0;
        end
        else if (en)
        begin
            out_ch.valid <= dv;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_ch.data <= dres;
        end
    end

    `ASSERT_NEXT(a_hold, clk, rst_n, out_ch.valid && !out_ch.ready, out_ch.valid, "output dropped")
    `ASSERT_IMPL(a_status, clk, rst_n, out_ch.valid, out_ch.data.status == ST_OK || out_ch.data.status == ST_WZERO || out_ch.data.status == ST_SAT, "bad status")
    `ASSERT_IMPL(a_wz, clk, rst_n, out_ch.valid && out_ch.data.status == ST_WZERO, out_ch.data.out_x == 0 && out_ch.data.out_z == 0, "wzero nonzero")
endmodule

### sim/m4pt_checker.sv
`timescale 1ns / 1ps
module m4pt_checker import m4pt_pkg::*; (
    input  logic   clk,
    input  logic   rst_n,
    m4pt_in_if     in_ch,
    m4pt_out_if    out_ch,
    m4pt_cfg_if    cfg_ch,
    output int     errors,
    output int     pending
);

    logic [63:0] matrix_regs [NUM_REGS];
    item_out_t   expected_q [$];

    function automatic logic signed [127:0] elem_of(int r, int c);
        logic signed [31:0] e;
        e = matrix_regs[2 * r + c / 2][32 * (c % 2) +: 32];
        return 128'(e);
    endfunction

    // signed num / positive den, half away from zero, clamp to 32 bits
    function automatic logic [31:0] round_clamp(input logic signed [127:0] num,
                                                input logic [127:0] den,
                                                inout bit sat);
        logic        neg;
        logic [127:0] mag;
        logic [127:0] q;
        logic [127:0] lim;
        neg = num[127];
        mag = neg ? -num : num;
        q   = ((mag << 1) + den) / (den << 1);
        lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
        if (q > lim)
        begin
            sat = 1'b1;
            return neg ? 32'h8000_0000 : 32'h7fff_ffff;
        end
        return neg ? -q[31:0] : q[31:0];
    endfunction

    function automatic item_out_t transform(item_in_t it);
        logic signed [127:0] sums [4];
        logic signed [127:0] vec [3];
        logic signed [127:0] num;
        logic [127:0]        den;
        logic [31:0]         res [3];
        item_out_t           o;
        bit                  sat;
        sat = 1'b0;
        vec[0] = 128'(it.in_x);
        vec[1] = 128'(it.in_y);
        vec[2] = 128'(it.in_z);
        for (int r = 0; r < 4; r++)
        begin
            sums[r] = '0;
            for (int c = 0; c < 3; c++)
                sums[r] = sums[r] + elem_of(r, c) * vec[c];
            if (it.command == CMD_POINT)
                sums[r] = sums[r] + elem_of(r, 3) * (128'sd1 <<< FRAC_BITS);
        end
        if (it.command == CMD_POINT)
        begin
            if (sums[3] == 0)
            begin
                o.out_x  = '0;
                o.out_y  = '0;
                o.out_z  = '0;
                o.status = ST_WZERO;
                return o;
            end
            den = sums[3][127] ? -sums[3] : sums[3];
            for (int r = 0; r < 3; r++)
            begin
                num = sums[r] <<< FRAC_BITS;
                if (sums[3][127])
                    num = -num;
                res[r] = round_clamp(num, den, sat);
            end
        end
        else
        begin
            den = 128'd1 << FRAC_BITS;
            for (int r = 0; r < 3; r++)
                res[r] = round_clamp(sums[r], den, sat);
        end
        o.out_x  = res[0];
        o.out_y  = res[1];
        o.out_z  = res[2];
        o.status = sat ? ST_SAT : ST_OK;
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        item_out_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
                matrix_regs[i] = CFG_RESET[i];
            expected_q.delete();
            errors  = 0;
            pending = 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("result with nothing expected: %h", out_ch.data);
                    errors++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (out_ch.data.out_x !== want.out_x)
                    begin
                        $error("out_x expected %h actual %h", want.out_x, out_ch.data.out_x);
                        errors++;
                    end
                    if (out_ch.data.out_y !== want.out_y)
                    begin
                        $error("out_y expected %h actual %h", want.out_y, out_ch.data.out_y);
                        errors++;
                    end
                    if (out_ch.data.out_z !== want.out_z)
                    begin
                        $error("out_z expected %h actual %h", want.out_z, out_ch.data.out_z);
                        errors++;
                    end
                    if (out_ch.data.status !== want.status)
                    begin
                        $error("status expected %0d actual %0d", want.status,
                               out_ch.data.status);
                        errors++;
                    end
                end
            end
            if (in_ch.valid && in_ch.ready)
                expected_q.push_back(transform(in_ch.data));
            if (cfg_ch.valid && cfg_ch.ready && cfg_ch.index < NUM_REGS)
                matrix_regs[cfg_ch.index] = cfg_ch.wdata;
            pending = expected_q.size();
        end
    end

endmodule

### sim/tb_matrix4_point_transform_core.sv
`timescale 1ns / 1ps
module tb_matrix4_point_transform_core;
    import m4pt_pkg::*;

    localparam logic [IDX_W-1:0] REG_ROW0_COLS01 = 3'd0;
    localparam logic [IDX_W-1:0] REG_ROW0_COLS23 = 3'd1;
    localparam logic [IDX_W-1:0] REG_ROW1_COLS01 = 3'd2;
    localparam logic [IDX_W-1:0] REG_ROW1_COLS23 = 3'd3;
    localparam logic [IDX_W-1:0] REG_ROW2_COLS01 = 3'd4;
    localparam logic [IDX_W-1:0] REG_ROW2_COLS23 = 3'd5;
    localparam logic [IDX_W-1:0] REG_ROW3_COLS01 = 3'd6;
    localparam logic [IDX_W-1:0] REG_ROW3_COLS23 = 3'd7;
    localparam int PIPE_LAT  = 4 + DIV_STEPS + 1;
    localparam int MAX_CYCLES = 400000;
    localparam logic [31:0] FIX_ONE = 32'h0001_0000;
    localparam logic [31:0] FIX_MAX = 32'h7fff_ffff;
    localparam logic [31:0] FIX_MIN = 32'h8000_0000;

    logic clk;
    logic rst_n;
    int   errors;
    int   pending;
    bit   idle_en;
    int   items_sent;
    int   settings_used;
    int   cycles;

    m4pt_in_if  in_ch ();
    m4pt_out_if out_ch ();
    m4pt_cfg_if cfg_ch ();

    matrix4_point_transform_core u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch)
    );

    m4pt_checker u_checker (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .cfg_ch  (cfg_ch),
        .errors  (errors),
        .pending (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > MAX_CYCLES)
            begin
                $display("FAIL matrix4_point_transform_core");
                $finish;
            end
        end
    end

    // receiver stalls in bursts
    initial
    begin
        int n;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (idle_en && $urandom_range(0, 5) == 0)
            begin
                out_ch.ready <= 1'b0;
                n = $urandom_range(1, 10);
                repeat (n) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            n = $urandom_range(1, 20);
            repeat (n - 1) @(posedge clk);
        end
    end

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return FIX_MAX;
            2: return FIX_MIN;
            3: return $urandom_range(0, 1) ? 32'h0 : 32'hffff_ffff;
            default: return 32'($signed($urandom_range(0, 1 << 25)) - (1 << 24));
        endcase
    endfunction

    function automatic logic [31:0] rand_elem();
        case ($urandom_range(0, 7))
            0: return $urandom();
            1: return 32'h0;
            2: return FIX_ONE;
            3: return $urandom_range(0, 1) ? FIX_MAX : FIX_MIN;
            default: return 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
        endcase
    endfunction

    task automatic send_item(logic cmd, logic [31:0] x, logic [31:0] y, logic [31:0] z);
        int n;
        if (idle_en && $urandom_range(0, 4) == 0)
        begin
            in_ch.valid <= 1'b0;
            n = $urandom_range(1, 10);
            repeat (n) @(posedge clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.data.command <= cmd;
        in_ch.data.in_x    <= x;
        in_ch.data.in_y    <= y;
        in_ch.data.in_z    <= z;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (PIPE_LAT) @(posedge clk);
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [63:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.wdata <= val;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_rows(logic [31:0] m [16]);
        for (int i = 0; i < NUM_REGS; i++)
            write_reg(IDX_W'(i), {m[2 * i + 1], m[2 * i]});
        settings_used++;
    endtask

    task automatic extreme_items();
        send_item(CMD_POINT, FIX_MAX, FIX_MIN, 32'h0);
        send_item(CMD_VECTOR, FIX_MAX, FIX_MIN, 32'hffff_ffff);
        send_item(CMD_POINT, FIX_MIN, FIX_MIN, FIX_MIN);
        send_item(CMD_VECTOR, FIX_MAX, FIX_MAX, FIX_MAX);
        send_item(CMD_POINT, FIX_ONE, 32'hffff_8000, 32'h0000_8000);
    endtask

    initial
    begin
        logic [31:0] m [16];
        int per_phase;
        in_ch.valid   = 1'b0;
        in_ch.data    = '0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.index  = '0;
        cfg_ch.wdata  = '0;
        idle_en       = 1'b1;
        items_sent    = 0;
        settings_used = 1;
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // identity after reset
        extreme_items();
        send_item(CMD_POINT, 32'h0, 32'h0, 32'h0);
        drain();

        // scale 2.0 with translation: saturation in both modes
        m = '{default: 32'h0};
        m[0] = 32'h0002_0000; m[5] = 32'h0002_0000; m[10] = 32'h0002_0000;
        m[3] = 32'h0003_0000; m[15] = FIX_ONE;
        load_rows(m);
        extreme_items();
        send_item(CMD_VECTOR, 32'h3fff_ffff, 32'hc000_0000, 32'h0001_0000);
        drain();

        // w row zeroed: point mode hits the zero-w case, vector mode ignores row 3
        write_reg(REG_ROW3_COLS01, 64'h0);
        write_reg(REG_ROW3_COLS23, 64'h0);
        extreme_items();
        drain();

        // negative w with half-step ties
        write_reg(REG_ROW3_COLS23, {32'hfffe_0000, 32'h0});
        write_reg(REG_ROW0_COLS01, {32'h0, FIX_ONE});
        write_reg(REG_ROW0_COLS23, 64'h0);
        write_reg(REG_ROW1_COLS01, {FIX_ONE, 32'h0});
        write_reg(REG_ROW1_COLS23, 64'h0);
        write_reg(REG_ROW2_COLS01, 64'h0);
        write_reg(REG_ROW2_COLS23, {32'h0, FIX_ONE});
        send_item(CMD_POINT, 32'h0000_0001, 32'hffff_ffff, 32'h0000_0003);
        send_item(CMD_POINT, FIX_MIN, FIX_MAX, 32'h0);
        send_item(CMD_VECTOR, 32'h0000_0001, 32'hffff_ffff, 32'h0000_0003);
        drain();

        // all elements at the limits
        m = '{default: FIX_MAX};
        load_rows(m);
        extreme_items();
        drain();
        m = '{default: FIX_MIN};
        load_rows(m);
        extreme_items();
        drain();

        for (int ph = 0; ph < 12; ph++)
        begin
            for (int i = 0; i < 16; i++)
                m[i] = rand_elem();
            // occasional affine w row, occasional zero w row
            case ($urandom_range(0, 3))
                0: begin m[12] = 0; m[13] = 0; m[14] = 0; m[15] = FIX_ONE; end
                1: begin m[12] = 0; m[13] = 0; m[14] = 0; m[15] = 0; end
                default: ;
            endcase
            load_rows(m);
            idle_en = (ph < 10);
            per_phase = 75;
            for (int k = 0; k < per_phase; k++)
                send_item($urandom_range(0, 1) ? CMD_VECTOR : CMD_POINT,
                          rand_coord(), rand_coord(), rand_coord());
            drain();
        end

        $display("Sent %0d items across %0d matrix settings in point and vector modes,",
                 items_sent, settings_used);
        $display("with zero-w, saturation, rounding ties and random stalls on both sides.");
        if (errors == 0)
            $display("PASS matrix4_point_transform_core");
        else
            $display("FAIL matrix4_point_transform_core");
        $finish;
    end

endmodule

### filelist.f
+incdir+hdl
hdl/m4pt_pkg.sv
hdl/m4pt_if.sv
hdl/m4pt_divpipe.sv
hdl/matrix4_point_transform_core.sv
sim/m4pt_checker.sv
sim/tb_matrix4_point_transform_core.sv
